// ===== src/rhsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_pkg
// Shared constants and types of the RGB to HSL converter: hue sector codes,
// the per-pixel control flags and the angle constants of the hue wheel.
// ----------------------------------------------------------------------------
package rhsl_pkg;

    localparam int SECTOR_DEG      = 60;
    localparam int TURN_DEG        = 360;
    localparam int GREEN_BASE_MULT = 2;
    localparam int BLUE_BASE_MULT  = 4;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic    gray;
        logic    neg;
        t_sector sector;
    } t_hue_ctrl;

endpackage
`default_nettype wire

// ===== src/rhsl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_front
// Two register stages ahead of the dividers: maximum, minimum, sum, hue
// sector and saturation divisor, then the scaled numerators of both quotients.
// ----------------------------------------------------------------------------
module rhsl_front
    import rhsl_pkg::*;
#(
    parameter int SAMPLE_BITS   = 8,
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_FRAC_BITS = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire logic [SAMPLE_BITS-1:0]                i_red,
    input  wire logic [SAMPLE_BITS-1:0]                i_green,
    input  wire logic [SAMPLE_BITS-1:0]                i_blue,
    output      logic                                  o_valid,
    output      t_hue_ctrl                             o_ctrl,
    output      logic [SAMPLE_BITS:0]                  o_light,
    output      logic [SAMPLE_BITS+$clog2((SECTOR_DEG << HUE_FRAC_BITS)+1)-1:0] o_hnum,
    output      logic [SAMPLE_BITS+SAT_FRAC_BITS-1:0]  o_snum,
    output      logic [SAMPLE_BITS-1:0]                o_delta,
    output      logic [SAMPLE_BITS-1:0]                o_den
);

    localparam int SB    = SAMPLE_BITS;
    localparam int SIXTY = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int HQW   = $clog2(SIXTY + 1);
    localparam int HNW   = SB + HQW;
    localparam int SNW   = SB + SAT_FRAC_BITS;
    localparam int SMAX  = (1 << SB) - 1;

    logic [SB-1:0] n_mx;
    logic [SB-1:0] n_mn;
    logic [SB:0]   n_sum;
    logic [SB:0]   n_den_full;
    logic [SB-1:0] n_pos;
    logic [SB-1:0] n_negv;
    t_hue_ctrl     n_ctrl;
    logic [SB-1:0] n_absdiff;

    always_comb begin
        n_mx = i_red;
        n_mn = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx)  n_mx = i_blue;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn)  n_mn = i_blue;
        n_sum = {1'b0, n_mx} + {1'b0, n_mn};
        if (n_sum < (SB+1)'(SMAX)) begin
            n_den_full = n_sum;
        end else begin
            n_den_full = (SB+1)'(2 * SMAX) - n_sum;
        end
    end

    always_comb begin
        n_ctrl.gray = (n_mx == n_mn);
        if (i_red == n_mx) begin
            n_ctrl.sector = SECT_RED;
            n_pos         = i_green;
            n_negv        = i_blue;
        end else if (i_green == n_mx) begin
            n_ctrl.sector = SECT_GREEN;
            n_pos         = i_blue;
            n_negv        = i_red;
        end else begin
            n_ctrl.sector = SECT_BLUE;
            n_pos         = i_red;
            n_negv        = i_green;
        end
        n_ctrl.neg = (n_pos < n_negv);
        n_absdiff  = n_ctrl.neg ? (n_negv - n_pos) : (n_pos - n_negv);
    end

    logic          r1_valid;
    t_hue_ctrl     r1_ctrl;
    logic [SB:0]   r1_sum;
    logic [SB-1:0] r1_delta;
    logic [SB-1:0] r1_den;
    logic [SB-1:0] r1_absdiff;

    logic           r2_valid;
    t_hue_ctrl      r2_ctrl;
    logic [SB:0]    r2_sum;
    logic [SB-1:0]  r2_delta;
    logic [SB-1:0]  r2_den;
    logic [HNW-1:0] r2_hnum;
    logic [SNW-1:0] r2_snum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctrl    <= n_ctrl;
            r1_sum     <= n_sum;
            r1_delta   <= n_mx - n_mn;
            r1_den     <= n_den_full[SB-1:0];
            r1_absdiff <= n_absdiff;
            r2_ctrl    <= r1_ctrl;
            r2_sum     <= r1_sum;
            r2_delta   <= r1_delta;
            r2_den     <= r1_den;
            r2_hnum    <= HNW'(r1_absdiff) * HNW'(SIXTY);
            r2_snum    <= {r1_delta, {SAT_FRAC_BITS{1'b0}}};
        end
    end

    assign o_valid = r2_valid;
    assign o_ctrl  = r2_ctrl;
    assign o_light = r2_sum;
    assign o_hnum  = r2_hnum;
    assign o_snum  = r2_snum;
    assign o_delta = r2_delta;
    assign o_den   = r2_den;

endmodule
`default_nettype wire

// ===== src/rhsl_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_div_pipe
// Pipelined restoring divider with a hue lane and a saturation lane. Each
// stage settles one quotient bit of both lanes, most significant bit first.
// ----------------------------------------------------------------------------
module rhsl_div_pipe
    import rhsl_pkg::*;
#(
    parameter int SAMPLE_BITS = 8,
    parameter int QUO_W       = 13,
    parameter int HNUM_W      = 20,
    parameter int SNUM_W      = 20
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire t_hue_ctrl              i_ctrl,
    input  wire logic [SAMPLE_BITS:0]   i_light,
    input  wire logic [HNUM_W-1:0]      i_hnum,
    input  wire logic [SNUM_W-1:0]      i_snum,
    input  wire logic [SAMPLE_BITS-1:0] i_delta,
    input  wire logic [SAMPLE_BITS-1:0] i_den,
    output      logic                   o_valid,
    output      t_hue_ctrl              o_ctrl,
    output      logic [SAMPLE_BITS:0]   o_light,
    output      logic [QUO_W-1:0]       o_hquo,
    output      logic                   o_hrem_nz,
    output      logic [QUO_W-1:0]       o_squo
);

    localparam int SB = SAMPLE_BITS;
    localparam int RW = SB + QUO_W;

    logic            r_valid [QUO_W];
    t_hue_ctrl       r_ctrl  [QUO_W];
    logic [SB:0]     r_light [QUO_W];
    logic [RW-1:0]   r_hrem  [QUO_W];
    logic [SB-1:0]   r_hden  [QUO_W];
    logic [QUO_W-1:0] r_hquo [QUO_W];
    logic [RW-1:0]   r_srem  [QUO_W];
    logic [SB-1:0]   r_sden  [QUO_W];
    logic [QUO_W-1:0] r_squo [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int K = QUO_W - 1 - s;

        logic             w_valid;
        t_hue_ctrl        w_ctrl;
        logic [SB:0]      w_light;
        logic [RW-1:0]    w_hrem;
        logic [SB-1:0]    w_hden;
        logic [QUO_W-1:0] w_hquo;
        logic [RW-1:0]    w_srem;
        logic [SB-1:0]    w_sden;
        logic [QUO_W-1:0] w_squo;
        logic [RW-1:0]    n_hcmp;
        logic [RW-1:0]    n_scmp;
        logic             n_hge;
        logic             n_sge;

        if (s == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_ctrl  = i_ctrl;
            assign w_light = i_light;
            assign w_hrem  = RW'(i_hnum);
            assign w_hden  = i_delta;
            assign w_hquo  = '0;
            assign w_srem  = RW'(i_snum);
            assign w_sden  = i_den;
            assign w_squo  = '0;
        end else begin : g_next
            assign w_valid = r_valid[s-1];
            assign w_ctrl  = r_ctrl[s-1];
            assign w_light = r_light[s-1];
            assign w_hrem  = r_hrem[s-1];
            assign w_hden  = r_hden[s-1];
            assign w_hquo  = r_hquo[s-1];
            assign w_srem  = r_srem[s-1];
            assign w_sden  = r_sden[s-1];
            assign w_squo  = r_squo[s-1];
        end

        assign n_hcmp = {{QUO_W{1'b0}}, w_hden} << K;
        assign n_scmp = {{QUO_W{1'b0}}, w_sden} << K;
        assign n_hge  = (w_hrem >= n_hcmp);
        assign n_sge  = (w_srem >= n_scmp);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctrl[s]     <= w_ctrl;
                r_light[s]    <= w_light;
                r_hden[s]     <= w_hden;
                r_sden[s]     <= w_sden;
                r_hrem[s]     <= n_hge ? (w_hrem - n_hcmp) : w_hrem;
                r_srem[s]     <= n_sge ? (w_srem - n_scmp) : w_srem;
                r_hquo[s]     <= w_hquo | (QUO_W'(n_hge) << K);
                r_squo[s]     <= w_squo | (QUO_W'(n_sge) << K);
            end
        end
    end

    assign o_valid   = r_valid[QUO_W-1];
    assign o_ctrl    = r_ctrl[QUO_W-1];
    assign o_light   = r_light[QUO_W-1];
    assign o_hquo    = r_hquo[QUO_W-1];
    assign o_hrem_nz = (r_hrem[QUO_W-1] != '0);
    assign o_squo    = r_squo[QUO_W-1];

endmodule
`default_nettype wire

// ===== src/rhsl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsl_back
// Final hue assembly (sector base, rounding toward minus infinity, wrap into
// one turn), gray masking, and the output register with its skid stage.
// ----------------------------------------------------------------------------
module rhsl_back
    import rhsl_pkg::*;
#(
    parameter int SAMPLE_BITS   = 8,
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_FRAC_BITS = 12,
    parameter int QUO_W         = 13
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_valid,
    input  wire t_hue_ctrl                                   i_ctrl,
    input  wire logic [SAMPLE_BITS:0]                        i_light,
    input  wire logic [QUO_W-1:0]                            i_hquo,
    input  wire logic                                        i_hrem_nz,
    input  wire logic [QUO_W-1:0]                            i_squo,
    output      logic                                        o_ready,
    output      logic                                        o_valid,
    input  wire logic                                        i_ready,
    output      logic [$clog2(TURN_DEG << HUE_FRAC_BITS)-1:0] o_hue,
    output      logic [SAT_FRAC_BITS:0]                      o_sat,
    output      logic [SAMPLE_BITS:0]                        o_light
);

    localparam int SIXTY = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int TURN  = TURN_DEG << HUE_FRAC_BITS;
    localparam int HW    = $clog2(TURN);
    localparam int HQW   = $clog2(SIXTY + 1);
    localparam int SW    = SAT_FRAC_BITS + 1;
    localparam int LW    = SAMPLE_BITS + 1;

    logic [HQW:0]    n_hmag;
    logic [HW:0]     n_base;
    logic [HW:0]     n_hsum;
    logic [HW:0]     n_hfix;
    logic [HW-1:0]   n_hue;
    logic [SW-1:0]   n_sat;

    always_comb begin
        case (i_ctrl.sector)
            SECT_GREEN: n_base = (HW+1)'(GREEN_BASE_MULT * SIXTY);
            SECT_BLUE:  n_base = (HW+1)'(BLUE_BASE_MULT * SIXTY);
            default:    n_base = '0;
        endcase
        if (i_ctrl.neg) begin
            n_hmag = {1'b0, i_hquo[HQW-1:0]} + (HQW+1)'(i_hrem_nz);
            n_hsum = n_base - (HW+1)'(n_hmag);
        end else begin
            n_hmag = {1'b0, i_hquo[HQW-1:0]};
            n_hsum = n_base + (HW+1)'(n_hmag);
        end
        n_hfix = n_hsum[HW] ? (n_hsum + (HW+1)'(TURN)) : n_hsum;
        n_hue  = i_ctrl.gray ? '0 : n_hfix[HW-1:0];
        n_sat  = i_ctrl.gray ? '0 : i_squo[SW-1:0];
    end

    logic          r_out_v;
    logic [HW-1:0] r_out_hue;
    logic [SW-1:0] r_out_sat;
    logic [LW-1:0] r_out_light;
    logic          r_skid_v;
    logic [HW-1:0] r_skid_hue;
    logic [SW-1:0] r_skid_sat;
    logic [LW-1:0] r_skid_light;

    logic n_stall;
    assign n_stall = r_out_v && !i_ready;
    assign o_ready = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (n_stall) begin
            if (i_valid && !r_skid_v) r_skid_v <= 1'b1;
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_stall) begin
            if (!r_skid_v) begin
                r_skid_hue   <= n_hue;
                r_skid_sat   <= n_sat;
                r_skid_light <= i_light;
            end
        end else if (r_skid_v) begin
            r_out_hue   <= r_skid_hue;
            r_out_sat   <= r_skid_sat;
            r_out_light <= r_skid_light;
        end else begin
            r_out_hue   <= n_hue;
            r_out_sat   <= n_sat;
            r_out_light <= i_light;
        end
    end

    assign o_valid = r_out_v;
    assign o_hue   = r_out_hue;
    assign o_sat   = r_out_sat;
    assign o_light = r_out_light;

    a_skid_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_ready))
        else $error("skid stage filled while the output was free");

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a result ahead of an empty output");

    a_hue_in_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_hue < HW'(TURN)))
        else $error("hue outside one full turn");

    a_sat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_sat <= SW'(1 << SAT_FRAC_BITS)))
        else $error("saturation above full scale");

endmodule
`default_nettype wire

// ===== src/rgb_to_hsl_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert
// Streaming RGB to HSL pixel converter with pipelined dividers.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while o_s_axis_tready is high and returns
// one HSL result per pixel in the same order. The pipeline holds two front
// stages for the extremes and numerators, one divider stage per quotient bit
// (QUO_W bits, the larger of SAT_FRAC_BITS + 1 and the bit count of a
// sixty-degree hue step), and the output register. A skid stage at the output
// registers the input ready, so the downstream ready has no combinational path
// to it; once a downstream stall ends, the pipeline holds while the skid stage
// empties.
module rgb_to_hsl_convert
    import rhsl_pkg::*;
#(
    parameter int SAMPLE_BITS   = 8,
    parameter int HUE_FRAC_BITS = 6,
    parameter int SAT_FRAC_BITS = 12
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output      logic o_s_axis_tready,
    // Fields from bit 0 up: red, green, blue, zero padding.
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output      logic o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // Fields from bit 0 up: hue, saturation, lightness_twice, zero padding.
    output      logic [(($clog2(TURN_DEG << HUE_FRAC_BITS) + SAT_FRAC_BITS + SAMPLE_BITS + 2
                         + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int SIXTY  = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int HQW    = $clog2(SIXTY + 1);
    localparam int SW     = SAT_FRAC_BITS + 1;
    localparam int QUO_W  = (SW > HQW) ? SW : HQW;
    localparam int HNW    = SB + HQW;
    localparam int SNW    = SB + SAT_FRAC_BITS;
    localparam int HW     = $clog2(TURN_DEG << HUE_FRAC_BITS);
    localparam int LW     = SB + 1;
    localparam int OUT_W  = HW + SW + LW;
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

    logic           w_en;
    logic           w_f_valid;
    t_hue_ctrl      w_f_ctrl;
    logic [SB:0]    w_f_light;
    logic [HNW-1:0] w_f_hnum;
    logic [SNW-1:0] w_f_snum;
    logic [SB-1:0]  w_f_delta;
    logic [SB-1:0]  w_f_den;

    logic             w_d_valid;
    t_hue_ctrl        w_d_ctrl;
    logic [SB:0]      w_d_light;
    logic [QUO_W-1:0] w_d_hquo;
    logic             w_d_hrem_nz;
    logic [QUO_W-1:0] w_d_squo;

    logic [HW-1:0] w_hue;
    logic [SW-1:0] w_sat;
    logic [LW-1:0] w_light;

    rhsl_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .HUE_FRAC_BITS(HUE_FRAC_BITS),
        .SAT_FRAC_BITS(SAT_FRAC_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(i_s_axis_tvalid),
        .i_red  (i_s_axis_tdata[SB-1:0]),
        .i_green(i_s_axis_tdata[2*SB-1:SB]),
        .i_blue (i_s_axis_tdata[3*SB-1:2*SB]),
        .o_valid(w_f_valid),
        .o_ctrl (w_f_ctrl),
        .o_light(w_f_light),
        .o_hnum (w_f_hnum),
        .o_snum (w_f_snum),
        .o_delta(w_f_delta),
        .o_den  (w_f_den)
    );

    rhsl_div_pipe #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .QUO_W      (QUO_W),
        .HNUM_W     (HNW),
        .SNUM_W     (SNW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_f_valid),
        .i_ctrl   (w_f_ctrl),
        .i_light  (w_f_light),
        .i_hnum   (w_f_hnum),
        .i_snum   (w_f_snum),
        .i_delta  (w_f_delta),
        .i_den    (w_f_den),
        .o_valid  (w_d_valid),
        .o_ctrl   (w_d_ctrl),
        .o_light  (w_d_light),
        .o_hquo   (w_d_hquo),
        .o_hrem_nz(w_d_hrem_nz),
        .o_squo   (w_d_squo)
    );

    rhsl_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .HUE_FRAC_BITS(HUE_FRAC_BITS),
        .SAT_FRAC_BITS(SAT_FRAC_BITS),
        .QUO_W        (QUO_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_d_valid),
        .i_ctrl   (w_d_ctrl),
        .i_light  (w_d_light),
        .i_hquo   (w_d_hquo),
        .i_hrem_nz(w_d_hrem_nz),
        .i_squo   (w_d_squo),
        .o_ready  (w_en),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_hue    (w_hue),
        .o_sat    (w_sat),
        .o_light  (w_light)
    );

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tdata  = OUT_DW'({w_light, w_sat, w_hue});

endmodule
`default_nettype wire

// ===== bench/rhsl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsl_checker
// Watches both stream channels of the RGB to HSL converter. For every
// accepted pixel request it computes the expected hue, saturation and
// doubled lightness in fixed point. It then compares each accepted result
// field by field with the oldest expectation and counts every failure.
// ----------------------------------------------------------------------------
module rhsl_checker
    import rhsl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // Fields from bit 0 up: red, green, blue.
    input  wire logic [23:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // Fields from bit 0 up: hue, saturation, lightness_twice, zero padding.
    input  wire logic [39:0] i_m_tdata,
    output      int          o_fail_count,
    output      int          o_pending
);

    localparam int HUE_FRAC  = 6;
    localparam int SAT_FRAC  = 12;
    localparam int FULL      = 255;

    typedef struct packed {
        logic [8:0]  light2;
        logic [12:0] sat;
        logic [14:0] hue;
    } t_hsl;

    t_hsl expected_hsl_q[$];

    function automatic t_hsl predict_hsl(input logic [7:0] red, input logic [7:0] green,
                                         input logic [7:0] blue);
        int      r, g, b, mx, mn, sum, delta, den, sixty, hue, sat, pos, negv, base;
        t_sector sect;
        t_hsl    res;
        r = red;
        g = green;
        b = blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        sixty = SECTOR_DEG << HUE_FRAC;
        hue = 0;
        sat = 0;
        if (mx != mn) begin
            delta = mx - mn;
            den = (sum < FULL) ? sum : (2 * FULL - sum);
            sat = (delta << SAT_FRAC) / den;
            if (r == mx) sect = SECT_RED;
            else if (g == mx) sect = SECT_GREEN;
            else sect = SECT_BLUE;
            case (sect)
                SECT_RED: begin
                    pos = g; negv = b; base = 0;
                end
                SECT_GREEN: begin
                    pos = b; negv = r; base = GREEN_BASE_MULT * sixty;
                end
                default: begin
                    pos = r; negv = g; base = BLUE_BASE_MULT * sixty;
                end
            endcase
            // The hue is floored, so a negative offset rounds away from zero.
            if (pos >= negv) hue = base + ((pos - negv) * sixty) / delta;
            else hue = base - (((negv - pos) * sixty) + delta - 1) / delta;
            if (hue < 0) hue += TURN_DEG << HUE_FRAC;
        end
        res.hue    = hue[14:0];
        res.sat    = sat[12:0];
        res.light2 = sum[8:0];
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_hsl want;
        t_hsl got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expected_hsl_q.push_back(predict_hsl(i_s_tdata[7:0], i_s_tdata[15:8],
                                                     i_s_tdata[23:16]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[36:0];
                if (expected_hsl_q.size() == 0) begin
                    $error("Result 0x%0h arrived with no pixel outstanding.", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_hsl_q.pop_front();
                    if (got.hue !== want.hue) begin
                        $error("hue: expected %0d, actual %0d", want.hue, got.hue);
                    end
                    if (got.sat !== want.sat) begin
                        $error("saturation: expected %0d, actual %0d", want.sat, got.sat);
                    end
                    if (got.light2 !== want.light2) begin
                        $error("lightness_twice: expected %0d, actual %0d",
                               want.light2, got.light2);
                    end
                    if (got !== want) o_fail_count <= o_fail_count + 1;
                end
            end
        end
        o_pending <= expected_hsl_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the RGB to HSL converter. It first sends a set
// of directed corner pixels and then random pixels, with random idling on
// both channels and a drain pause. A checker module judges every result.
// ----------------------------------------------------------------------------
module tb_top;
    import rhsl_pkg::*;

    localparam int LATENCY      = 16;
    localparam int RANDOM_ITEMS = 1330;
    localparam int STALL_LIMIT  = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        calm = 1'b0;
    int          fail_count;
    int          pending;
    int          stall_cycles = 0;
    int          sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rgb_to_hsl_convert DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    rhsl_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 26);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request or result moved for %0d cycles.", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Called and returning at a falling edge.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Random pixel, biased toward near-gray pixels, the sum threshold, channels at 0 or 255 and ties.
    function automatic logic [23:0] random_pixel();
        int          mx, mn, mid;
        logic [23:0] px;
        logic [7:0]  c [3];
        px = 24'($urandom);
        case ($urandom_range(0, 9))
            6: begin
                mn = $urandom_range(0, 250);
                c[0] = 8'(mn + $urandom_range(0, 5));
                c[1] = 8'(mn + $urandom_range(0, 5));
                c[2] = 8'(mn + $urandom_range(0, 5));
                px = {c[2], c[1], c[0]};
            end
            7: begin
                mx = $urandom_range(128, 255);
                mn = $urandom_range(253, 257) - mx;
                if (mn < 0) mn = 0;
                if (mn > mx) mn = mx;
                mid = $urandom_range(mn, mx);
                case ($urandom_range(0, 5))
                    0: px = {8'(mn), 8'(mid), 8'(mx)};
                    1: px = {8'(mid), 8'(mn), 8'(mx)};
                    2: px = {8'(mn), 8'(mx), 8'(mid)};
                    3: px = {8'(mx), 8'(mn), 8'(mid)};
                    4: px = {8'(mid), 8'(mx), 8'(mn)};
                    default: px = {8'(mx), 8'(mid), 8'(mn)};
                endcase
            end
            8: begin
                px[8 * $urandom_range(0, 2) +: 8] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            9: begin
                c[0] = px[7:0];
                if ($urandom_range(0, 1)) px[15:8] = c[0];
                else px[23:16] = c[0];
            end
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        logic [23:0] px;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd100, 8'd0,   8'd1);
        send_pixel(8'd10,  8'd0,   8'd5);
        send_pixel(8'd200, 8'd55,  8'd100);
        send_pixel(8'd254, 8'd0,   8'd100);
        send_pixel(8'd255, 8'd200, 8'd100);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd50,  8'd200, 8'd10);
        send_pixel(8'd30,  8'd10,  8'd200);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd170, 8'd85,  8'd170);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm <= (i >= 500) && (i < 720);
            if (i == 900) drain();
            px = random_pixel();
            send_pixel(px[7:0], px[15:8], px[23:16]);
        end
        calm <= 1'b0;
        drain();
        repeat (4 * LATENCY) @(negedge i_clk);

        $display("Run covered %0d pixels: directed gray, primary, tie and threshold cases,",
                 sent);
        $display("then random pixels under random idling on both channels and a drain pause.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
